>>> hdl/lowest_free_id_allocator_macros.svh
// Assertion macros for the lowest free identifier allocator.
// Included by the top level; no other dependencies.
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define LFID_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LFID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LFID_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LFID_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/lfid_pkg.sv
// Shared constants, types and the lowest-set-bit encoder of the identifier allocator.
// Used by lowest_free_id_allocator; depends on nothing.
`timescale 1ns / 1ps

package lfid_pkg;

    localparam int POOL_SIZE = 8192;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W = $clog2(POOL_SIZE);
    localparam int ID_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [ID_W-1:0] FIRST_ID_RESET = 16'd300;
    localparam logic [ID_W-1:0] LAST_ID_RESET = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ID = 2'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PICK = 4'b0100,
        S_RCHK = 4'b1000
    } t_state;

    // Position of the lowest set bit, found byte first and then bit within the byte.
    function automatic logic [5:0] lowest_one(input logic [WORD_BITS-1:0] v);
        logic [7:0] byte_any;
        logic [7:0] sel;
        logic [2:0] bsel;
        logic [2:0] bidx;
        int i;
        for (i = 0; i < 8; i++) begin
            byte_any[i] = |v[i*8 +: 8];
        end
        bsel = 3'd0;
        for (i = 7; i >= 0; i--) begin
            if (byte_any[i]) begin
                bsel = 3'(i);
            end
        end
        sel = v[bsel*8 +: 8];
        bidx = 3'd0;
        for (i = 7; i >= 0; i--) begin
            if (sel[i]) begin
                bidx = 3'(i);
            end
        end
        return {bsel, bidx};
    endfunction

endpackage

>>> hdl/lowest_free_id_allocator.sv
// Lowest free identifier allocator: a used-bit map in a 64-bit wide word memory.
// Depends on lfid_pkg and lowest_free_id_allocator_macros.svh.
// An allocate scans map words upward from word 0, sets the first free bit and grants it; a
// release clears its bit if set; an empty pool or a release out of range answers from idle.
// One word is in flight. Reset is synchronous: registers return to 300 and 5000, per-word
// valid bits clear the map. Each result is strobed on o_done and the receiver cannot stall.
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_opcode,
    input  logic [lfid_pkg::ID_W-1:0]      i_request_id,
    output logic                           o_done,
    output logic [lfid_pkg::ID_W-1:0]      o_granted_id,
    output logic [1:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lfid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lfid_pkg::ID_W-1:0]      i_cfg_data
);

    localparam int WB = lfid_pkg::WORD_BITS;
    localparam int WA = lfid_pkg::WA_W;
    localparam int OW = lfid_pkg::OFF_W;
    localparam int IW = lfid_pkg::ID_W;

    lfid_pkg::t_state  r_state, n_state;
    lfid_pkg::t_status r_status, n_status;
    logic              r_done, n_done;
    logic [IW-1:0]     r_granted, n_granted;
    logic [IW-1:0]     r_first_id, n_first_id;
    logic [IW-1:0]     r_last_id, n_last_id;
    logic [WA-1:0]     r_word, n_word;
    logic [OW-1:0]     r_last_off, n_last_off;
    logic [OW-1:0]     r_off, n_off;
    logic [IW-1:0]     r_req, n_req;
    logic [WB-1:0]     r_free, n_free;
    logic [WB-1:0]     r_wdata, n_wdata;

    logic [WB-1:0]     r_mem [lfid_pkg::MAP_WORDS];
    logic [lfid_pkg::MAP_WORDS-1:0] r_valid;
    logic [WB-1:0]     r_rd_data;
    logic              r_rd_valid;

    logic              mem_we;
    logic [WA-1:0]     mem_waddr;
    logic [WB-1:0]     mem_wdata;

    logic [IW:0]       top_id;
    logic [IW-1:0]     eff_top;
    logic              pool_empty;
    logic              req_in_range;
    logic [WB-1:0]     word_data;
    logic [WB-1:0]     limit_mask;
    logic [WB-1:0]     free_bits;
    logic [WA-1:0]     last_word;
    logic [5:0]        pick_idx;
    logic              done_fail;

    assign o_busy = (r_state != lfid_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done = r_done;
    assign o_granted_id = r_granted;
    assign o_status = r_status;
    assign done_fail = o_done && (o_status != lfid_pkg::ST_OK);

    always_comb begin
        top_id = {1'b0, r_first_id} + (IW+1)'(lfid_pkg::POOL_SIZE - 1);
        eff_top = ({1'b0, r_last_id} < top_id) ? r_last_id : top_id[IW-1:0];
        pool_empty = (eff_top < r_first_id);
        req_in_range = (i_request_id >= r_first_id) && (i_request_id <= eff_top);
        word_data = r_rd_valid ? r_rd_data : '0;
        last_word = WA'(r_last_off >> 6);
        limit_mask = (r_word == last_word) ? ({WB{1'b1}} >> (6'd63 - r_last_off[5:0]))
                                           : {WB{1'b1}};
        free_bits = ~word_data & limit_mask;
        pick_idx = lfid_pkg::lowest_one(r_free);
    end

    always_comb begin
        n_state = r_state;
        n_status = r_status;
        n_done = 1'b0;
        n_granted = r_granted;
        n_first_id = r_first_id;
        n_last_id = r_last_id;
        n_word = r_word;
        n_last_off = r_last_off;
        n_off = r_off;
        n_req = r_req;
        n_free = r_free;
        n_wdata = r_wdata;
        mem_we = 1'b0;
        mem_waddr = r_word;
        mem_wdata = r_wdata;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                lfid_pkg::CFG_FIRST_ID: n_first_id = i_cfg_data;
                lfid_pkg::CFG_LAST_ID:  n_last_id = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            lfid_pkg::S_IDLE: begin
                if (i_start) begin
                    n_last_off = OW'(eff_top - r_first_id);
                    n_off = OW'(i_request_id - r_first_id);
                    n_req = i_request_id;
                    if (i_opcode == lfid_pkg::OP_ALLOC) begin
                        if (pool_empty) begin
                            n_done = 1'b1;
                            n_granted = '0;
                            n_status = lfid_pkg::ST_EXHAUSTED;
                        end else begin
                            n_word = '0;
                            n_state = lfid_pkg::S_SCAN;
                        end
                    end else begin
                        if (!req_in_range) begin
                            n_done = 1'b1;
                            n_granted = '0;
                            n_status = lfid_pkg::ST_NOT_ALLOC;
                        end else begin
                            n_word = WA'(OW'(i_request_id - r_first_id) >> 6);
                            n_state = lfid_pkg::S_RCHK;
                        end
                    end
                end
            end
            lfid_pkg::S_SCAN: begin
                if (|free_bits) begin
                    n_free = free_bits;
                    n_wdata = word_data;
                    n_state = lfid_pkg::S_PICK;
                end else if (r_word == last_word) begin
                    n_done = 1'b1;
                    n_granted = '0;
                    n_status = lfid_pkg::ST_EXHAUSTED;
                    n_state = lfid_pkg::S_IDLE;
                end else begin
                    n_word = r_word + WA'(1);
                end
            end
            lfid_pkg::S_PICK: begin
                mem_we = 1'b1;
                mem_waddr = r_word;
                mem_wdata = r_wdata | (WB'(1) << pick_idx);
                n_done = 1'b1;
                n_granted = IW'(32'(r_first_id) + 32'({r_word, pick_idx}));
                n_status = lfid_pkg::ST_OK;
                n_state = lfid_pkg::S_IDLE;
            end
            lfid_pkg::S_RCHK: begin
                n_done = 1'b1;
                n_state = lfid_pkg::S_IDLE;
                if (word_data[r_off[5:0]]) begin
                    mem_we = 1'b1;
                    mem_waddr = r_word;
                    mem_wdata = word_data & ~(WB'(1) << r_off[5:0]);
                    n_granted = r_req;
                    n_status = lfid_pkg::ST_OK;
                end else begin
                    n_granted = '0;
                    n_status = lfid_pkg::ST_NOT_ALLOC;
                end
            end
            default: begin
                n_state = lfid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfid_pkg::S_IDLE;
            r_done <= 1'b0;
            r_first_id <= lfid_pkg::FIRST_ID_RESET;
            r_last_id <= lfid_pkg::LAST_ID_RESET;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
            r_first_id <= n_first_id;
            r_last_id <= n_last_id;
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_granted <= n_granted;
        r_word <= n_word;
        r_last_off <= n_last_off;
        r_off <= n_off;
        r_req <= n_req;
        r_free <= n_free;
        r_wdata <= n_wdata;
        r_rd_valid <= r_valid[n_word];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[n_word];
    end

    `LFID_ASSERT_SAME(a_done_when_idle, i_clk, i_rst_n, o_done, !o_busy)
    `LFID_ASSERT_NEXT(a_no_spurious_word, i_clk, i_rst_n, !o_busy && !i_start, !o_done)
    `LFID_ASSERT_SAME(a_fail_zero_id, i_clk, i_rst_n, done_fail, o_granted_id == '0)

endmodule
